>>> src/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared codes and field widths for the positional array list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pal_pkg;

  // fixed field widths of the request and response
  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  // request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd3;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // cell operations, broadcast along the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

endpackage

>>> src/pal_req_if.sv
// ----------------------------------------------------------------------------
// pal_req_if
// Request channel of the positional array list: command, position, value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pal_req_if;
  logic                                valid;
  logic                                ready;
  logic        [pal_pkg::CMD_W-1:0]    cmd;
  logic        [pal_pkg::POS_W-1:0]    position;
  logic signed [pal_pkg::DATA_W-1:0]   value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

>>> src/pal_rsp_if.sv
// ----------------------------------------------------------------------------
// pal_rsp_if
// Response channel of the positional array list: status, read data, found position and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pal_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pal_pkg::STATUS_W-1:0]  status;
  logic signed [pal_pkg::DATA_W-1:0]    read_value;
  logic        [pal_pkg::POS_W-1:0]     found_position;
  logic        [pal_pkg::POS_W-1:0]     entry_count;

  modport source (output valid, output status, output read_value, output found_position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input read_value, input found_position,
                  input entry_count, output ready);
endinterface

>>> src/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry and takes from a neighbour on shift or rotate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pal_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 4,
  parameter int INDEX       = 0
) (
  input  logic                    clk,
  input  pal_pkg::cell_op_t       op,
  input  logic [IDX_W-1:0]        idx,
  input  logic [VALUE_WIDTH-1:0]  ins_value,
  input  logic [VALUE_WIDTH-1:0]  left,
  input  logic [VALUE_WIDTH-1:0]  right,
  output logic [VALUE_WIDTH-1:0]  value
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  always_ff @(posedge clk) begin
    unique case (op)
      pal_pkg::OP_HOLD: begin
      end
      pal_pkg::OP_INSERT: begin
        if (MY_IDX == idx) begin
          value <= ins_value;
        end else if (MY_IDX > idx) begin
          value <= left;
        end
      end
      pal_pkg::OP_DELETE: begin
        if (MY_IDX >= idx) begin
          value <= right;
        end
      end
      pal_pkg::OP_ROTATE: begin
        // whole chain moves one place towards the head
        value <= right;
      end
    endcase
  end

endmodule

>>> src/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// positional_array_list_core
// Bounded ordered list in a chain of cells with insert, delete, read and find.
// Insert, delete and any refused request: the request is registered at accept, the
// response once the response slot is free. Throughput: insert and delete 1 request
// per cycle while the response side is ready, the cells shift in one step. Read and
// find rotate the whole chain once past the head comparator, one request at a time.
// Reset: synchronous, clears the count (list empty) and the handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_list_core #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  pal_req_if.sink       req,
  pal_rsp_if.source     rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = ((CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W) + 1;
  localparam int DW    = pal_pkg::DATA_W;
  localparam int PW    = pal_pkg::POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [1:0]                   state, state_next;
  logic [pal_pkg::CMD_W-1:0]    cmd_q;
  logic [PW-1:0]                pos_q;
  logic [VALUE_WIDTH-1:0]       val_q;
  logic [CNT_W-1:0]             count, count_next;
  logic [IDX_W-1:0]             scan_k, scan_k_next;
  logic                         hit, hit_next;
  logic [PW-1:0]                fpos, fpos_next;
  logic signed [DW-1:0]         rd, rd_next;

  logic                         out_valid, out_valid_next;
  logic [pal_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic signed [DW-1:0]         out_read, out_read_next;
  logic [PW-1:0]                out_found, out_found_next;
  logic [PW-1:0]                out_count, out_count_next;

  logic [VALUE_WIDTH-1:0]       cell_value [DEPTH];
  pal_pkg::cell_op_t            cell_op, exec_op;
  logic [IDX_W-1:0]             idx;
  logic [CW-1:0]                pos_ext, cnt_ext, idx_full;
  logic [pal_pkg::STATUS_W-1:0] exec_status;
  logic                         start_scan, out_free, exec_go, accept;
  logic [IDX_W:0]               k_plus;

  // ---------------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pal_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .idx       (idx),
      .ins_value (val_q),
      .left      (cell_value[(i + DEPTH - 1) % DEPTH]),
      .right     (cell_value[(i + 1) % DEPTH]),
      .value     (cell_value[i])
    );
  end

  // ---------------------------------------------------------------------------
  // request decode
  // ---------------------------------------------------------------------------
  assign pos_ext  = CW'(pos_q);
  assign cnt_ext  = CW'(count);
  assign idx_full = pos_ext - CW'(1);
  assign idx      = idx_full[IDX_W-1:0];
  assign k_plus   = {1'b0, scan_k} + (IDX_W + 1)'(1);

  always_comb begin
    exec_status = pal_pkg::ST_OK;
    exec_op     = pal_pkg::OP_HOLD;
    start_scan  = 1'b0;
    unique case (cmd_q)
      pal_pkg::CMD_INSERT: begin
        if (cnt_ext == CW'(DEPTH)) begin
          exec_status = pal_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CW'(1)) begin
          exec_status = pal_pkg::ST_BADPOS;
        end else begin
          exec_op = pal_pkg::OP_INSERT;
        end
      end
      pal_pkg::CMD_DELETE: begin
        if (cnt_ext == '0) begin
          exec_status = pal_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          exec_status = pal_pkg::ST_BADPOS;
        end else begin
          exec_op = pal_pkg::OP_DELETE;
        end
      end
      pal_pkg::CMD_READ: begin
        if (cnt_ext == '0) begin
          exec_status = pal_pkg::ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          exec_status = pal_pkg::ST_BADPOS;
        end else begin
          start_scan = 1'b1;
        end
      end
      pal_pkg::CMD_FIND: begin
        if (cnt_ext == '0) begin
          exec_status = pal_pkg::ST_NOTFOUND;
        end else begin
          start_scan = 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid || rsp.ready;
  assign exec_go   = (state == S_EXEC) && out_free;
  assign req.ready = (state == S_IDLE) || (exec_go && !start_scan);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_k_next     = scan_k;
    hit_next        = hit;
    fpos_next       = fpos;
    rd_next         = rd;
    cell_op         = pal_pkg::OP_HOLD;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_read_next   = out_read;
    out_found_next  = out_found;
    out_count_next  = out_count;

    if (exec_go) begin
      if (start_scan) begin
        state_next  = S_SCAN;
        scan_k_next = '0;
        hit_next    = 1'b0;
        fpos_next   = '0;
        rd_next     = '0;
      end else begin
        cell_op = exec_op;
        if (exec_op == pal_pkg::OP_INSERT) begin
          count_next = count + CNT_W'(1);
        end else if (exec_op == pal_pkg::OP_DELETE) begin
          count_next = count - CNT_W'(1);
        end
        out_valid_next  = 1'b1;
        out_status_next = exec_status;
        out_read_next   = '0;
        out_found_next  = '0;
        out_count_next  = PW'(CW'(count_next));
        state_next      = S_IDLE;
      end
    end

    if (state == S_SCAN) begin
      // head cell shows entry scan_k in this cycle
      cell_op     = pal_pkg::OP_ROTATE;
      scan_k_next = scan_k + IDX_W'(1);
      if (cmd_q == pal_pkg::CMD_READ && scan_k == idx) begin
        rd_next = DW'(signed'(cell_value[0]));
      end
      if (cmd_q == pal_pkg::CMD_FIND && !hit && CW'(scan_k) < cnt_ext
          && cell_value[0] == val_q) begin
        hit_next  = 1'b1;
        fpos_next = PW'(k_plus);
      end
      if (scan_k == LAST_IDX) begin
        state_next      = S_IDLE;
        out_valid_next  = 1'b1;
        out_status_next = (cmd_q == pal_pkg::CMD_READ || hit_next) ? pal_pkg::ST_OK
                                                                  : pal_pkg::ST_NOTFOUND;
        out_read_next   = rd_next;
        out_found_next  = fpos_next;
        out_count_next  = PW'(CW'(count));
      end
    end

    if (accept) begin
      state_next = S_EXEC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.cmd;
      pos_q <= req.position;
      val_q <= VALUE_WIDTH'($unsigned(req.value));
    end
    scan_k     <= scan_k_next;
    hit        <= hit_next;
    fpos       <= fpos_next;
    rd         <= rd_next;
    out_status <= out_status_next;
    out_read   <= out_read_next;
    out_found  <= out_found_next;
    out_count  <= out_count_next;
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = out_read;
  assign rsp.found_position = out_found;
  assign rsp.entry_count    = out_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list count beyond depth");

  a_scan_slot_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !out_valid)
    else $error("response slot occupied during rotation");

  a_scan_ends_with_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_k == LAST_IDX) |=> (rsp.valid && state != S_SCAN))
    else $error("rotation finished without a response");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (exec_go && !start_scan && exec_op == pal_pkg::OP_INSERT)
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !req.ready)
    else $error("request taken during rotation");
`endif

endmodule
